/* design/stkq_pkg.sv */
// Shared types and constants for the single touch key qualifier.
`timescale 1ns / 1ps

package stkq_pkg;

	localparam int KEY_COUNT_DEF = 8;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int SPAN_W = 16;
	localparam int TIME_W = 32;
	localparam int OUT_W  = 4;

	localparam logic [SPAN_W-1:0] PRESS_STABLE_RST   = 16'd40;
	localparam logic [SPAN_W-1:0] RELEASE_STABLE_RST = 16'd120;

	localparam logic [1:0] OP_EDGE    = 2'd0;
	localparam logic [1:0] OP_POLL    = 2'd1;
	localparam logic [1:0] OP_DISCARD = 2'd2;

	localparam logic REG_PRESS   = 1'b0;
	localparam logic REG_RELEASE = 1'b1;

	typedef struct packed {
		logic [1:0]        op;
		logic [7:0]        pad;
		logic              pressed;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [SPAN_W-1:0] press_stable_ms;
		logic [SPAN_W-1:0] rearm_quiet_ms;
	} cfg_t;

endpackage

/* design/stkq_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module stkq_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [stkq_pkg::ADDR_W-1:0]  paddr,
	input  logic [stkq_pkg::DATA_W-1:0]  pwdata,
	output logic [stkq_pkg::DATA_W-1:0]  prdata,
	output stkq_pkg::cfg_t               cfg
);
	import stkq_pkg::*;

	logic [SPAN_W-1:0] press_q;
	logic [SPAN_W-1:0] release_q;
	logic              wr;
	logic              idx;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= PRESS_STABLE_RST;
			release_q <= RELEASE_STABLE_RST;
		end else if (wr) begin
			case (idx)
				REG_PRESS: press_q <= pwdata[SPAN_W-1:0];
				REG_RELEASE: release_q <= pwdata[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PRESS: prdata = DATA_W'(press_q);
			REG_RELEASE: prdata = DATA_W'(release_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.press_stable_ms = press_q;
	assign cfg.rearm_quiet_ms  = release_q;

endmodule

/* design/stkq_core.sv */
// Qualifier state and its combinational update, registered on fire, for one transaction.
`timescale 1ns / 1ps

module stkq_core #(
	parameter int KEY_COUNT = stkq_pkg::KEY_COUNT_DEF,
	parameter int PAD_W     = $clog2(KEY_COUNT + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  stkq_pkg::item_t             item,
	input  stkq_pkg::cfg_t              cfg,
	output logic [stkq_pkg::OUT_W-1:0]  result
);
	import stkq_pkg::*;

	localparam logic [KEY_COUNT-1:0] ONE_BIT = KEY_COUNT'(1);

	logic [KEY_COUNT-1:0] mask_q, mask_n;
	logic                 armed_q, armed_n;
	logic                 rw_q, rw_n;
	logic [PAD_W-1:0]     cand_q, cand_n;
	logic [TIME_W-1:0]    ctime_q, ctime_n;
	logic [TIME_W-1:0]    rtime_q, rtime_n;

	logic                 pad_ok;
	logic [7:0]           pad_m1;
	logic [KEY_COUNT-1:0] pbit;
	logic [PAD_W-1:0]     pad_num;
	logic [PAD_W-1:0]     cand_m1;
	logic [KEY_COUNT-1:0] cbit;
	logic [KEY_COUNT-1:0] set_mask;
	logic [TIME_W-1:0]    press_age;
	logic [TIME_W-1:0]    release_age;
	logic                 press_done;
	logic                 release_done;
	logic [7:0]           cand_wide;

	always_comb begin
		pad_ok       = (item.pad != 8'd0) && (32'(item.pad) <= 32'(KEY_COUNT));
		pad_m1       = item.pad - 8'd1;
		pbit         = pad_ok ? (ONE_BIT << pad_m1) : '0;
		pad_num      = item.pad[PAD_W-1:0];
		cand_m1      = cand_q - PAD_W'(1);
		cbit         = ONE_BIT << cand_m1;
		set_mask     = mask_q | pbit;
		press_age    = item.now_ms - ctime_q;
		release_age  = item.now_ms - rtime_q;
		press_done   = press_age >= TIME_W'(cfg.press_stable_ms);
		release_done = release_age >= TIME_W'(cfg.rearm_quiet_ms);
		cand_wide    = 8'(cand_q);

		mask_n  = mask_q;
		armed_n = armed_q;
		rw_n    = rw_q;
		cand_n  = cand_q;
		ctime_n = ctime_q;
		rtime_n = rtime_q;
		result  = '0;

		case (item.op)
			OP_EDGE: begin
				if (pad_ok) begin
					if (item.pressed) begin
						if ((mask_q & pbit) == '0) begin
							mask_n = set_mask;
							rw_n   = 1'b0;
							if (armed_q) begin
								if (set_mask == pbit && cand_q == '0) begin
									cand_n  = pad_num;
									ctime_n = item.now_ms;
								end else begin
									cand_n  = '0;
									armed_n = 1'b0;
								end
							end
						end
					end else begin
						mask_n = mask_q & ~pbit;
						if (armed_q && cand_q == pad_num)
							cand_n = '0;
						// A disarmed block restarts its quiet timer on every release
						// that leaves no pad down.
						if (!armed_q && (mask_q & ~pbit) == '0) begin
							rw_n    = 1'b1;
							rtime_n = item.now_ms;
						end
					end
				end
			end
			OP_POLL: begin
				if (!armed_q) begin
					if (rw_q && mask_q == '0 && release_done) begin
						armed_n = 1'b1;
						rw_n    = 1'b0;
					end
				end else if (cand_q != '0 && mask_q == cbit && press_done) begin
					result  = cand_wide[OUT_W-1:0];
					cand_n  = '0;
					armed_n = 1'b0;
					rw_n    = 1'b0;
				end
			end
			OP_DISCARD: begin
				mask_n  = '0;
				cand_n  = '0;
				ctime_n = '0;
				armed_n = 1'b0;
				rw_n    = 1'b1;
				rtime_n = item.now_ms;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			armed_q <= 1'b1;
			rw_q    <= 1'b0;
			cand_q  <= '0;
			ctime_q <= '0;
			rtime_q <= '0;
		end else if (fire) begin
			mask_q  <= mask_n;
			armed_q <= armed_n;
			rw_q    <= rw_n;
			cand_q  <= cand_n;
			ctime_q <= ctime_n;
			rtime_q <= rtime_n;
		end
	end

endmodule

/* design/single_touch_key_qualifier_core.sv */
// Top level of the single touch key qualifier.
`timescale 1ns / 1ps

// Takes one transaction per clock cycle while the output is not stalled by
// out_ready: an edge event, a poll or a discard-until-quiet request. Each
// transaction yields exactly one result, accepted_pad, which is nonzero only
// for a poll that accepts a lone held pad. A transaction is captured in an
// input register; its result is computed as it leaves that register and is
// held in the output register that drives accepted_pad. The rate is set by
// the update of the debounce state in stkq_core. While a result waits for
// out_ready, the input register can still take one more transaction.
// press_stable_ms sits at byte address 0 and rearm_quiet_ms at 4; write
// them only while no transaction is in flight.
module single_touch_key_qualifier_core #(
	parameter int KEY_COUNT = stkq_pkg::KEY_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [7:0]                   pad,
	input  logic                         pressed,
	input  logic [stkq_pkg::TIME_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [stkq_pkg::OUT_W-1:0]   accepted_pad,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [stkq_pkg::ADDR_W-1:0]  paddr,
	input  logic [stkq_pkg::DATA_W-1:0]  pwdata,
	output logic [stkq_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import stkq_pkg::*;

	localparam int PAD_W = $clog2(KEY_COUNT + 1);

	item_t             item_s1;
	logic              valid_s1;
	logic              advance;
	logic              out_valid_q;
	logic [OUT_W-1:0]  accepted_pad_q;
	logic [OUT_W-1:0]  result;
	cfg_t              cfg;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op      <= op;
			item_s1.pad     <= pad;
			item_s1.pressed <= pressed;
			item_s1.now_ms  <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			accepted_pad_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign accepted_pad = accepted_pad_q;

	stkq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	stkq_core #(
		.KEY_COUNT (KEY_COUNT),
		.PAD_W     (PAD_W)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

endmodule

/* design/stkq_checker.sv */
// Port-level checks for the single touch key qualifier, bound to the top level.
`timescale 1ns / 1ps

module stkq_checker #(
	parameter int KEY_COUNT = stkq_pkg::KEY_COUNT_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [stkq_pkg::OUT_W-1:0]   accepted_pad,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [stkq_pkg::ADDR_W-1:0]  paddr,
	input logic [stkq_pkg::DATA_W-1:0]  pwdata,
	input logic [stkq_pkg::DATA_W-1:0]  prdata,
	input logic                         pready
);
	import stkq_pkg::*;

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// With the output side empty the block can always take a transaction.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while no result was waiting");

	// An accepted pad is never beyond the configured pad count.
	a_pad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (KEY_COUNT >= 16) || (32'(accepted_pad) <= 32'(KEY_COUNT)))
		else $error("accepted pad out of range");

	// A written register reads back its low 16 bits on the next cycle.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=>
		(!psel || paddr[2] != $past(paddr[2]) ||
		prdata == DATA_W'($past(pwdata[SPAN_W-1:0]))))
		else $error("register read-back mismatch");

	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[DATA_W-1:SPAN_W] == '0)
		else $error("unused register bits read nonzero");

endmodule

bind single_touch_key_qualifier_core stkq_checker #(
	.KEY_COUNT (KEY_COUNT)
) u_stkq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.accepted_pad (accepted_pad),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.pready       (pready)
);
